/* sv/prcr_pkg.sv */
// Shared types, field widths, defaults and function codes for the preroll capture ring.
package prcr_pkg;

   localparam int DEF_CAPACITY     = 262144;
   localparam int DEF_SAMPLE_WIDTH = 32;

   localparam int FUNC_W = 2;
   localparam int WORD_W = 32;
   localparam int POS_W  = 63;
   localparam int LEN_W  = 24;
   localparam int CNT_W  = 19;
   localparam int CTR_W  = 64;

   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [CTR_W-1:0]  ctr_type;

   localparam func_type FUNC_PUSH    = 2'd0;
   localparam func_type FUNC_PREROLL = 2'd1;
   localparam func_type FUNC_RECENT  = 2'd2;
   localparam func_type FUNC_READ    = 2'd3;

endpackage

/* sv/prcr_sample_ram.sv */
// Single-port-write, registered-read sample memory for the capture ring.
module prcr_sample_ram #(
   parameter int ADDR_W = $clog2(prcr_pkg::DEF_CAPACITY),
   parameter int DATA_W = prcr_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_mem [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/preroll_capture_ring_unit.sv */
// Top level of the preroll capture ring: sequencer, counters and window arithmetic.
//
//   channel   direction  handshake                 payload
//   req_      in         start & !busy accepts     func, sample, seg_start, seg_len,
//                                                  preroll_len, max_recent, read_pos
//   rsp_      out        rsp_valid, one cycle      sample_out, window_start,
//                                                  preroll_count, segment_count,
//                                                  total_count, has_data
//
// Push ends in ST_IDLE, read in ST_RD_WAIT after one memory read, recent in ST_RC_START;
// preroll runs a chain of 64-bit compares and subtracts, one per step, to ST_PR_END.
// The registered response strobe rises in the cycle after the last step of a word.
// Reset clears the sample count and last segment end; memory contents stay undefined.
// busy is held high during reset; the receiver cannot stall, so otherwise busy
// reflects only the sequencer.
module preroll_capture_ring_unit #(
   parameter int CAPACITY     = prcr_pkg::DEF_CAPACITY,
   parameter int SAMPLE_WIDTH = prcr_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  prcr_pkg::func_type req_func,
   input  prcr_pkg::word_type req_sample,
   input  prcr_pkg::pos_type  req_seg_start,
   input  prcr_pkg::len_type  req_seg_len,
   input  prcr_pkg::cnt_type  req_preroll_len,
   input  prcr_pkg::cnt_type  req_max_recent,
   input  prcr_pkg::pos_type  req_read_pos,
   output logic               rsp_valid,
   output prcr_pkg::word_type rsp_sample_out,
   output prcr_pkg::pos_type  rsp_window_start,
   output prcr_pkg::cnt_type  rsp_preroll_count,
   output prcr_pkg::cnt_type  rsp_segment_count,
   output prcr_pkg::cnt_type  rsp_total_count,
   output logic               rsp_has_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = AW + 1;
   localparam int MW = (CW > prcr_pkg::CNT_W) ? CW : prcr_pkg::CNT_W;
   localparam int LW = (CW > prcr_pkg::LEN_W) ? CW : prcr_pkg::LEN_W;

   typedef logic [CW-1:0] cw_type;
   typedef logic [MW-1:0] mw_type;
   typedef logic [LW-1:0] lw_type;

   localparam prcr_pkg::ctr_type CAP_CTR = prcr_pkg::ctr_type'(CAPACITY);
   localparam cw_type            CAP_CW  = cw_type'(CAPACITY);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RD_WAIT  = 4'd1;
   localparam logic [3:0] ST_PR_WANT  = 4'd2;
   localparam logic [3:0] ST_PR_LAST  = 4'd3;
   localparam logic [3:0] ST_PR_OLD   = 4'd4;
   localparam logic [3:0] ST_PR_DIFF  = 4'd5;
   localparam logic [3:0] ST_PR_SAT   = 4'd6;
   localparam logic [3:0] ST_PR_SEG   = 4'd7;
   localparam logic [3:0] ST_PR_END   = 4'd8;
   localparam logic [3:0] ST_RC_SIZE  = 4'd9;
   localparam logic [3:0] ST_RC_COUNT = 4'd10;
   localparam logic [3:0] ST_RC_START = 4'd11;

   logic [3:0] state_ff, state_in;

   prcr_pkg::ctr_type pushed_ff, pushed_in;
   prcr_pkg::ctr_type last_end_ff, last_end_in;

   prcr_pkg::pos_type seg_begin_ff, seg_begin_in;
   prcr_pkg::len_type seg_len_ff, seg_len_in;
   prcr_pkg::cnt_type preroll_len_ff, preroll_len_in;
   prcr_pkg::cnt_type max_recent_ff, max_recent_in;

   prcr_pkg::ctr_type want_ff, want_in;
   prcr_pkg::ctr_type oldest_ff, oldest_in;
   prcr_pkg::ctr_type diff_ff, diff_in;
   cw_type            pre_ff, pre_in;
   cw_type            seg_cnt_ff, seg_cnt_in;
   cw_type            size_ff, size_in;
   cw_type            count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   prcr_pkg::word_type rsp_sample_ff, rsp_sample_in;
   prcr_pkg::pos_type  rsp_start_ff, rsp_start_in;
   prcr_pkg::cnt_type  rsp_pre_ff, rsp_pre_in;
   prcr_pkg::cnt_type  rsp_seg_ff, rsp_seg_in;
   prcr_pkg::cnt_type  rsp_total_ff, rsp_total_in;
   logic               rsp_has_ff, rsp_has_in;

   logic                    accept;
   logic                    mem_wr_en;
   logic                    mem_rd_en;
   logic [63:0]             push_wide;
   logic [63:0]             rd_wide;
   logic [SAMPLE_WIDTH-1:0] mem_rd_data;
   logic [64:0]             diff_wide;
   cw_type                  room;

   assign busy   = reset | (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   assign mem_wr_en = accept && (req_func == prcr_pkg::FUNC_PUSH);
   assign mem_rd_en = accept && (req_func == prcr_pkg::FUNC_READ);
   assign push_wide = 64'(req_sample);
   assign rd_wide   = 64'(mem_rd_data);

   prcr_sample_ram #(
      .ADDR_W (AW),
      .DATA_W (SAMPLE_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (pushed_ff[AW-1:0]),
      .wr_data (push_wide[SAMPLE_WIDTH-1:0]),
      .rd_en   (mem_rd_en),
      .rd_addr (req_read_pos[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   // borrow out means the clamped start lies past the segment start
   assign diff_wide = {1'b0, prcr_pkg::ctr_type'(seg_begin_ff)} - {1'b0, want_ff};
   assign room      = CAP_CW - pre_ff;

   always_comb begin
      state_in       = state_ff;
      pushed_in      = pushed_ff;
      last_end_in    = last_end_ff;
      seg_begin_in   = seg_begin_ff;
      seg_len_in     = seg_len_ff;
      preroll_len_in = preroll_len_ff;
      max_recent_in  = max_recent_ff;
      want_in        = want_ff;
      oldest_in      = oldest_ff;
      diff_in        = diff_ff;
      pre_in         = pre_ff;
      seg_cnt_in     = seg_cnt_ff;
      size_in        = size_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      rsp_sample_in  = rsp_sample_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_pre_in     = rsp_pre_ff;
      rsp_seg_in     = rsp_seg_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_has_in     = rsp_has_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seg_begin_in   = req_seg_start;
               seg_len_in     = req_seg_len;
               preroll_len_in = req_preroll_len;
               max_recent_in  = req_max_recent;
               case (req_func)
                  prcr_pkg::FUNC_PUSH: begin
                     pushed_in     = pushed_ff + 64'd1;
                     rsp_valid_in  = 1'b1;
                     rsp_sample_in = '0;
                     rsp_start_in  = '0;
                     rsp_pre_in    = '0;
                     rsp_seg_in    = '0;
                     rsp_total_in  = '0;
                     rsp_has_in    = 1'b1;
                  end
                  prcr_pkg::FUNC_PREROLL: state_in = ST_PR_WANT;
                  prcr_pkg::FUNC_RECENT:  state_in = ST_RC_SIZE;
                  prcr_pkg::FUNC_READ:    state_in = ST_RD_WAIT;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_sample_in = prcr_pkg::word_type'(rd_wide);
            rsp_start_in  = '0;
            rsp_pre_in    = '0;
            rsp_seg_in    = '0;
            rsp_total_in  = '0;
            rsp_has_in    = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_PR_WANT: begin
            if (prcr_pkg::ctr_type'(preroll_len_ff) > prcr_pkg::ctr_type'(seg_begin_ff)) begin
               want_in = '0;
            end else begin
               want_in = prcr_pkg::ctr_type'(seg_begin_ff)
                       - prcr_pkg::ctr_type'(preroll_len_ff);
            end
            state_in = ST_PR_LAST;
         end
         ST_PR_LAST: begin
            want_in   = (want_ff < last_end_ff) ? last_end_ff : want_ff;
            oldest_in = (pushed_ff > CAP_CTR) ? pushed_ff - CAP_CTR : '0;
            state_in  = ST_PR_OLD;
         end
         ST_PR_OLD: begin
            want_in  = (want_ff < oldest_ff) ? oldest_ff : want_ff;
            state_in = ST_PR_DIFF;
         end
         ST_PR_DIFF: begin
            diff_in  = diff_wide[64] ? '0 : diff_wide[63:0];
            state_in = ST_PR_SAT;
         end
         ST_PR_SAT: begin
            pre_in   = (diff_ff > CAP_CTR) ? CAP_CW : cw_type'(diff_ff);
            state_in = ST_PR_SEG;
         end
         ST_PR_SEG: begin
            seg_cnt_in  = (lw_type'(seg_len_ff) > lw_type'(room)) ? room
                                                                  : cw_type'(seg_len_ff);
            last_end_in = prcr_pkg::ctr_type'(seg_begin_ff)
                        + prcr_pkg::ctr_type'(seg_len_ff);
            state_in    = ST_PR_END;
         end
         ST_PR_END: begin
            rsp_valid_in  = 1'b1;
            rsp_sample_in = '0;
            rsp_start_in  = prcr_pkg::pos_type'(prcr_pkg::ctr_type'(seg_begin_ff)
                                                - prcr_pkg::ctr_type'(pre_ff));
            rsp_pre_in    = prcr_pkg::cnt_type'(pre_ff);
            rsp_seg_in    = prcr_pkg::cnt_type'(seg_cnt_ff);
            rsp_total_in  = prcr_pkg::cnt_type'(pre_ff + seg_cnt_ff);
            rsp_has_in    = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_RC_SIZE: begin
            size_in  = (pushed_ff > CAP_CTR) ? CAP_CW : cw_type'(pushed_ff);
            state_in = ST_RC_COUNT;
         end
         ST_RC_COUNT: begin
            count_in = (mw_type'(size_ff) > mw_type'(max_recent_ff))
                     ? cw_type'(max_recent_ff) : size_ff;
            state_in = ST_RC_START;
         end
         ST_RC_START: begin
            rsp_valid_in  = 1'b1;
            rsp_sample_in = '0;
            rsp_seg_in    = '0;
            if (size_ff == '0) begin
               rsp_start_in = '0;
               rsp_pre_in   = '0;
               rsp_total_in = '0;
               rsp_has_in   = 1'b0;
            end else begin
               rsp_start_in = prcr_pkg::pos_type'(pushed_ff - prcr_pkg::ctr_type'(count_ff));
               rsp_pre_in   = prcr_pkg::cnt_type'(count_ff);
               rsp_total_in = prcr_pkg::cnt_type'(count_ff);
               rsp_has_in   = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pushed_ff    <= '0;
         last_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pushed_ff    <= pushed_in;
         last_end_ff  <= last_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_begin_ff   <= seg_begin_in;
      seg_len_ff     <= seg_len_in;
      preroll_len_ff <= preroll_len_in;
      max_recent_ff  <= max_recent_in;
      want_ff        <= want_in;
      oldest_ff      <= oldest_in;
      diff_ff        <= diff_in;
      pre_ff         <= pre_in;
      seg_cnt_ff     <= seg_cnt_in;
      size_ff        <= size_in;
      count_ff       <= count_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_pre_ff     <= rsp_pre_in;
      rsp_seg_ff     <= rsp_seg_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_has_ff     <= rsp_has_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_window_start  = rsp_start_ff;
   assign rsp_preroll_count = rsp_pre_ff;
   assign rsp_segment_count = rsp_seg_ff;
   assign rsp_total_count   = rsp_total_ff;
   assign rsp_has_data      = rsp_has_ff;

endmodule

/* dv/tb.sv */
// Testbench for preroll_capture_ring_unit: directed and random words checked by a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RING_CAP = prcr_pkg::DEF_CAPACITY;
   localparam int          SLOT_W   = $clog2(RING_CAP);
   localparam logic [63:0] CAP64    = 64'(RING_CAP);

   typedef struct {
      prcr_pkg::func_type func;
      prcr_pkg::word_type sample;
      prcr_pkg::pos_type  seg_begin;
      prcr_pkg::len_type  seg_len;
      prcr_pkg::cnt_type  preroll_len;
      prcr_pkg::cnt_type  max_recent;
      prcr_pkg::pos_type  read_pos;
   } ring_req_type;

   typedef struct {
      prcr_pkg::word_type sample_out;
      prcr_pkg::pos_type  window_start;
      prcr_pkg::cnt_type  preroll_count;
      prcr_pkg::cnt_type  segment_count;
      prcr_pkg::cnt_type  total_count;
      logic               has_data;
   } ring_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   prcr_pkg::func_type req_func = prcr_pkg::FUNC_PUSH;
   prcr_pkg::word_type req_sample = '0;
   prcr_pkg::pos_type  req_seg_start = '0;
   prcr_pkg::len_type  req_seg_len = '0;
   prcr_pkg::cnt_type  req_preroll_len = '0;
   prcr_pkg::cnt_type  req_max_recent = '0;
   prcr_pkg::pos_type  req_read_pos = '0;
   logic               rsp_valid;
   prcr_pkg::word_type rsp_sample_out;
   prcr_pkg::pos_type  rsp_window_start;
   prcr_pkg::cnt_type  rsp_preroll_count;
   prcr_pkg::cnt_type  rsp_segment_count;
   prcr_pkg::cnt_type  rsp_total_count;
   logic               rsp_has_data;

   // predictor state
   prcr_pkg::word_type ring_mem [RING_CAP];
   logic [63:0]        pushed_cnt = '0;
   logic [63:0]        prior_seg_end = '0;

   ring_rsp_type rsp_due [$];
   int           errors = 0;
   int           word_cnt = 0;
   bit           gaps_on = 1'b1;

   preroll_capture_ring_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_sample        (req_sample),
      .req_seg_start     (req_seg_start),
      .req_seg_len       (req_seg_len),
      .req_preroll_len   (req_preroll_len),
      .req_max_recent    (req_max_recent),
      .req_read_pos      (req_read_pos),
      .rsp_valid         (rsp_valid),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_window_start  (rsp_window_start),
      .rsp_preroll_count (rsp_preroll_count),
      .rsp_segment_count (rsp_segment_count),
      .rsp_total_count   (rsp_total_count),
      .rsp_has_data      (rsp_has_data)
   );

   always #5 clock = ~clock;

   // Computes the response to one word and advances the ring state.
   function automatic ring_rsp_type ring_response(input ring_req_type r);
      ring_rsp_type o;
      logic [63:0]  seg_s;
      logic [63:0]  want;
      logic [63:0]  oldest;
      logic [63:0]  size;
      logic [63:0]  pre;
      logic [63:0]  room;
      logic [63:0]  cnt;
      o = '{default: '0};
      o.has_data = 1'b1;
      seg_s = {1'b0, r.seg_begin};
      oldest = (pushed_cnt > CAP64) ? pushed_cnt - CAP64 : 64'd0;
      size = (pushed_cnt > CAP64) ? CAP64 : pushed_cnt;
      case (r.func)
         prcr_pkg::FUNC_PUSH: begin
            ring_mem[pushed_cnt[SLOT_W-1:0]] = r.sample;
            pushed_cnt = pushed_cnt + 64'd1;
         end
         prcr_pkg::FUNC_PREROLL: begin
            want = (64'(r.preroll_len) > seg_s) ? 64'd0 : seg_s - 64'(r.preroll_len);
            if (want < prior_seg_end) want = prior_seg_end;
            if (want < oldest) want = oldest;
            pre = (want < seg_s) ? seg_s - want : 64'd0;
            if (pre > CAP64) pre = CAP64;
            room = CAP64 - pre;
            o.preroll_count = prcr_pkg::cnt_type'(pre);
            o.segment_count = (64'(r.seg_len) > room) ? prcr_pkg::cnt_type'(room)
                                                      : prcr_pkg::cnt_type'(r.seg_len);
            o.total_count = o.preroll_count + o.segment_count;
            o.window_start = prcr_pkg::pos_type'(seg_s - pre);
            prior_seg_end = seg_s + 64'(r.seg_len);
         end
         prcr_pkg::FUNC_RECENT: begin
            if (size == 64'd0) begin
               o.has_data = 1'b0;
            end else begin
               cnt = (size > 64'(r.max_recent)) ? 64'(r.max_recent) : size;
               o.preroll_count = prcr_pkg::cnt_type'(cnt);
               o.total_count = prcr_pkg::cnt_type'(cnt);
               o.window_start = prcr_pkg::pos_type'(pushed_cnt - cnt);
            end
         end
         default: begin
            o.sample_out = ring_mem[r.read_pos[SLOT_W-1:0]];
         end
      endcase
      return o;
   endfunction

   function automatic prcr_pkg::pos_type rand_pos();
      return prcr_pkg::pos_type'({$urandom, $urandom});
   endfunction

   // Unused fields carry random junk so every bit toggles.
   function automatic ring_req_type rand_req(input prcr_pkg::func_type f);
      ring_req_type r;
      r.func = f;
      r.sample = $urandom;
      r.seg_begin = rand_pos();
      r.seg_len = prcr_pkg::len_type'($urandom);
      r.preroll_len = prcr_pkg::cnt_type'($urandom);
      r.max_recent = prcr_pkg::cnt_type'($urandom);
      r.read_pos = rand_pos();
      return r;
   endfunction

   // Retained position, or an alias of one with random upper bits; slot is always written.
   function automatic prcr_pkg::pos_type pick_read_pos(input bit alias_pos);
      logic [63:0]       oldest;
      logic [63:0]       size;
      logic [63:0]       p;
      prcr_pkg::pos_type q;
      oldest = (pushed_cnt > CAP64) ? pushed_cnt - CAP64 : 64'd0;
      size = (pushed_cnt > CAP64) ? CAP64 : pushed_cnt;
      p = oldest + ({$urandom, $urandom} % size);
      q = prcr_pkg::pos_type'(p);
      if (alias_pos) begin
         q = rand_pos();
         q[SLOT_W-1:0] = p[SLOT_W-1:0];
      end
      return q;
   endfunction

   function automatic prcr_pkg::pos_type near_head();
      int unsigned d;
      d = $urandom_range(0, 700);
      if ($urandom_range(0, 9) == 0) begin
         return prcr_pkg::pos_type'(pushed_cnt + $urandom_range(0, 40));
      end
      return (pushed_cnt > 64'(d)) ? prcr_pkg::pos_type'(pushed_cnt - 64'(d)) : '0;
   endfunction

   task automatic send_word(input ring_req_type r);
      ring_rsp_type due;
      req_func = r.func;
      req_sample = r.sample;
      req_seg_start = r.seg_begin;
      req_seg_len = r.seg_len;
      req_preroll_len = r.preroll_len;
      req_max_recent = r.max_recent;
      req_read_pos = r.read_pos;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      due = ring_response(r);
      rsp_due.push_back(due);
      word_cnt++;
      @(negedge clock);
   endtask

   task automatic send_push(input prcr_pkg::word_type w);
      ring_req_type r;
      r = rand_req(prcr_pkg::FUNC_PUSH);
      r.sample = w;
      send_word(r);
   endtask

   task automatic send_preroll(input prcr_pkg::pos_type s, input prcr_pkg::cnt_type pl,
                               input prcr_pkg::len_type sl);
      ring_req_type r;
      r = rand_req(prcr_pkg::FUNC_PREROLL);
      r.seg_begin = s;
      r.preroll_len = pl;
      r.seg_len = sl;
      send_word(r);
   endtask

   task automatic send_recent(input prcr_pkg::cnt_type m);
      ring_req_type r;
      r = rand_req(prcr_pkg::FUNC_RECENT);
      r.max_recent = m;
      send_word(r);
   endtask

   task automatic send_read(input prcr_pkg::pos_type p);
      ring_req_type r;
      r = rand_req(prcr_pkg::FUNC_READ);
      r.read_pos = p;
      send_word(r);
   endtask

   task automatic sender_gap();
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   task automatic wait_all_results();
      start = 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%t tb: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      ring_rsp_type due;
      if (!reset && rsp_valid) begin
         if (rsp_due.size() == 0) begin
            errors++;
            $display("%t tb: response with none expected, expected none actual window %h",
                     $time, rsp_window_start);
         end else begin
            due = rsp_due.pop_front();
            check_field("sample_out", 64'(due.sample_out), 64'(rsp_sample_out));
            check_field("window_start", 64'(due.window_start), 64'(rsp_window_start));
            check_field("preroll_count", 64'(due.preroll_count), 64'(rsp_preroll_count));
            check_field("segment_count", 64'(due.segment_count), 64'(rsp_segment_count));
            check_field("total_count", 64'(due.total_count), 64'(rsp_total_count));
            check_field("has_data", 64'(due.has_data), 64'(rsp_has_data));
         end
      end
   end

   task automatic test_empty_ring();
      send_recent(prcr_pkg::cnt_type'(5));
      send_recent('0);
      send_preroll('0, '0, '0);
      // preroll longer than the segment start, segment longer than the ring
      send_preroll(prcr_pkg::pos_type'(10), '1, '1);
      send_preroll('0, '0, '0);
   endtask

   task automatic test_push_read();
      send_push('0);
      send_push('1);
      send_push(32'hA5A5_A5A5);
      send_push(32'h5A5A_5A5A);
      send_push($urandom);
      send_push($urandom);
      send_read('0);
      send_read({{(prcr_pkg::POS_W-SLOT_W){1'b1}}, SLOT_W'(1)});
      send_read(prcr_pkg::pos_type'(5));
   endtask

   task automatic test_preroll_cases();
      // far segment start: preroll saturates at the ring size
      send_preroll('1, '1, '0);
      // last segment end lies past this start: no history
      send_preroll(prcr_pkg::pos_type'(3), prcr_pkg::cnt_type'(2), prcr_pkg::len_type'(1));
      send_preroll(prcr_pkg::pos_type'(6), prcr_pkg::cnt_type'(1), '1);
      send_preroll(prcr_pkg::pos_type'(5), prcr_pkg::cnt_type'(5), '0);
      send_preroll('0, '0, '0);
   endtask

   task automatic test_recent_cases();
      send_recent('0);
      send_recent(prcr_pkg::cnt_type'(3));
      send_recent('1);
   endtask

   task automatic test_random_traffic(input int n, input bit vary_gaps);
      ring_req_type r;
      int           target;
      int           burst;
      int unsigned  k;
      target = word_cnt + n;
      while (word_cnt < target) begin
         if (vary_gaps && $urandom_range(0, 63) == 0) gaps_on = ~gaps_on;
         if ($urandom_range(0, 3) == 0) begin
            // capture sequence: pushes, a preroll over them, then look back
            burst = $urandom_range(1, 40);
            repeat (burst) begin
               sender_gap();
               send_push($urandom);
            end
            sender_gap();
            send_preroll(prcr_pkg::pos_type'(pushed_cnt - 64'($urandom_range(0, burst))),
                         prcr_pkg::cnt_type'($urandom_range(0, 300)),
                         prcr_pkg::len_type'($urandom_range(0, burst + 10)));
            sender_gap();
            send_recent(prcr_pkg::cnt_type'($urandom_range(0, 2 * burst)));
            repeat ($urandom_range(1, 3)) begin
               sender_gap();
               send_read(pick_read_pos(1'b0));
            end
         end else begin
            k = $urandom_range(0, 99);
            if (k < 45 || (k >= 77 && pushed_cnt == 64'd0)) begin
               r = rand_req(prcr_pkg::FUNC_PUSH);
               if ($urandom_range(0, 19) == 0) r.sample = $urandom_range(0, 1) ? '1 : '0;
            end else if (k < 62) begin
               r = rand_req(prcr_pkg::FUNC_PREROLL);
               case ($urandom_range(0, 9))
                  0: ;
                  1: r.seg_begin = prcr_pkg::pos_type'(prior_seg_end
                                                       - 64'($urandom_range(0, 20)));
                  default: r.seg_begin = near_head();
               endcase
               if ($urandom_range(0, 9) != 0) begin
                  r.preroll_len = prcr_pkg::cnt_type'($urandom_range(0, 800));
               end
               if ($urandom_range(0, 7) != 0) begin
                  r.seg_len = prcr_pkg::len_type'($urandom_range(0, 3000));
               end
            end else if (k < 77) begin
               r = rand_req(prcr_pkg::FUNC_RECENT);
               if ($urandom_range(0, 7) != 0) begin
                  r.max_recent = prcr_pkg::cnt_type'($urandom_range(0, 1200));
               end
            end else begin
               r = rand_req(prcr_pkg::FUNC_READ);
               r.read_pos = pick_read_pos($urandom_range(0, 4) == 0);
            end
            sender_gap();
            send_word(r);
         end
      end
   endtask

   task automatic test_long_history();
      logic [63:0] first_pos;
      send_preroll('0, '0, '0);
      first_pos = pushed_cnt;
      repeat (300) send_push($urandom);
      // history reaches back to the last segment end
      send_preroll(prcr_pkg::pos_type'(pushed_cnt), '1, '1);
      send_preroll(prcr_pkg::pos_type'(pushed_cnt - 64'd10), prcr_pkg::cnt_type'(RING_CAP),
                   prcr_pkg::len_type'(20));
      send_recent('1);
      send_read(prcr_pkg::pos_type'(first_pos));
      send_read(prcr_pkg::pos_type'(pushed_cnt - 64'd1));
      send_read(prcr_pkg::pos_type'(first_pos - 64'd1));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_ring();
      test_push_read();
      test_preroll_cases();
      test_recent_cases();
      wait_all_results();
      test_random_traffic(600, 1'b1);
      wait_all_results();
      gaps_on = 1'b0;
      test_long_history();
      gaps_on = 1'b1;
      test_random_traffic(650, 1'b1);
      gaps_on = 1'b0;
      test_random_traffic(150, 1'b0);
      start = 1'b0;
      repeat (2000) begin
         if (rsp_due.size() != 0) @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (rsp_due.size() != 0) begin
         errors++;
         $display("%t tb: responses missing, expected %0d actual 0", $time, rsp_due.size());
      end
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
